// ===== rtl/lifo_stack_with_search_macros.svh =====
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define LSS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define LSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lss_pkg.sv =====
// Shared constants and types of the stack with search.
package lss_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WORD_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_POP_RD = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

endpackage

// ===== rtl/lss_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lifo_stack_with_search.sv =====
// LIFO stack of signed words with push, pop and search; words live in one RAM.
// Push, overflow, empty pop, empty search and unused kinds: output register loaded at accept.
// Pop: RAM read of the top entry in ST_POP_RD, then the result stage ST_EMIT.
// Search: one RAM entry compared per cycle, from the top down to a hit or the bottom entry.
// One transaction is in work at a time; a result waiting in the output register holds off
// the next accept. Synchronous active-low reset empties the stack; RAM is not cleared.
`include "lifo_stack_with_search_macros.svh"

module lifo_stack_with_search #(
    parameter int DEPTH = lss_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lss_pkg::WORD_W-1:0]    s_axis_tdata,  // [31:0] value (signed)
    input  logic [lss_pkg::KIND_W-1:0]    s_axis_tuser,  // [1:0] kind
    // Result stream.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lss_pkg::WORD_W-1:0]    m_axis_tdata,  // [31:0] popped_word (signed)
    output logic [lss_pkg::STATUS_W:0]    m_axis_tuser   // [1:0] status, [2] found
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = lss_pkg::WORD_W;
    localparam int SW = lss_pkg::STATUS_W;

    lss_pkg::t_state r_state, n_state;

    // The fill count is the stack pointer: the top word sits at r_count - 1.
    logic [CW-1:0] r_count, n_count;
    // Search cursor: the entry whose read data arrives in the current cycle.
    logic [AW-1:0] r_idx, n_idx;
    logic signed [WW-1:0] r_key, n_key;

    // Result of a multi-cycle transaction, held until the output register is free.
    logic signed [WW-1:0] r_res_word, n_res_word;
    logic                 r_res_found, n_res_found;

    // Output register; it decouples the result stream from the engine.
    logic                 r_m_valid;
    logic signed [WW-1:0] r_m_word;
    logic [SW-1:0]        r_m_status;
    logic                 r_m_found;

    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_idle;
    logic                 w_in_search;
    logic                 w_full;
    logic                 w_empty;
    logic [CW-1:0]        w_top;
    logic [AW-1:0]        w_top_addr;
    logic                 w_push_full;
    logic                 w_out_overflow;

    logic                 w_we;
    logic [AW-1:0]        w_raddr;
    logic [WW-1:0]        w_rdata;
    logic                 w_hit;

    logic                 w_load;
    logic signed [WW-1:0] w_out_word;
    logic [SW-1:0]        w_out_status;
    logic                 w_out_found;

    lss_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_idle        = (r_state == lss_pkg::ST_IDLE);
    assign w_in_search   = (r_state == lss_pkg::ST_SEARCH);
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = w_idle && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_top      = r_count - 1'b1;
    assign w_top_addr = w_top[AW-1:0];
    assign w_hit      = ($signed(w_rdata) == r_key);

    // Short operations finish in the accept cycle and go straight to the output
    // register; a pop or a search of a non-empty stack walks through the RAM and finishes in ST_EMIT.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_res_word   = r_res_word;
        n_res_found  = r_res_found;
        w_we         = 1'b0;
        w_raddr      = w_top_addr;
        w_load       = 1'b0;
        w_out_word   = '0;
        w_out_status = lss_pkg::STATUS_OK;
        w_out_found  = 1'b0;

        unique case (r_state)
            lss_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    priority if (s_axis_tuser == lss_pkg::KIND_PUSH) begin
                        w_load = 1'b1;
                        if (w_full) begin
                            w_out_status = lss_pkg::STATUS_OVERFLOW;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (s_axis_tuser == lss_pkg::KIND_POP) begin
                        if (w_empty) begin
                            w_load       = 1'b1;
                            w_out_status = lss_pkg::STATUS_EMPTY;
                        end else begin
                            n_count = w_top;
                            n_state = lss_pkg::ST_POP_RD;
                        end
                    end else if (s_axis_tuser == lss_pkg::KIND_SEARCH) begin
                        if (w_empty) begin
                            w_load = 1'b1;
                        end else begin
                            n_idx   = w_top_addr;
                            n_key   = s_axis_tdata;
                            n_state = lss_pkg::ST_SEARCH;
                        end
                    end else begin
                        // Unused kind: no operation, all-zero result.
                        w_load = 1'b1;
                    end
                end
            end
            lss_pkg::ST_POP_RD: begin
                n_res_word  = w_rdata;
                n_res_found = 1'b0;
                n_state     = lss_pkg::ST_EMIT;
            end
            lss_pkg::ST_SEARCH: begin
                // Prefetch the next entry down while comparing the current one.
                w_raddr = r_idx - 1'b1;
                if (w_hit || (r_idx == '0)) begin
                    n_res_word  = '0;
                    n_res_found = w_hit;
                    n_state     = lss_pkg::ST_EMIT;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            lss_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_out_word  = r_res_word;
                    w_out_found = r_res_found;
                    n_state     = lss_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lss_pkg::ST_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_key       <= n_key;
        r_res_word  <= n_res_word;
        r_res_found <= n_res_found;
        if (w_load) begin
            r_m_word   <= w_out_word;
            r_m_status <= w_out_status;
            r_m_found  <= w_out_found;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_word;
    assign m_axis_tuser  = {r_m_found, r_m_status};

    // A push into a full stack must come out as an overflow result on the next cycle.
    assign w_push_full    = w_in_acc && (s_axis_tuser == lss_pkg::KIND_PUSH) && w_full;
    assign w_out_overflow = m_axis_tvalid && (m_axis_tuser[SW-1:0] == lss_pkg::STATUS_OVERFLOW);

    `LSS_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "fill count exceeds depth")
    `LSS_ASSERT_ALWAYS(a_ready_idle, !s_axis_tready || w_idle, "ready outside idle")
    `LSS_ASSERT_NEXT(a_overflow, w_push_full, w_out_overflow, "full push without overflow")
    `LSS_ASSERT_NEXT(a_search_keeps, w_in_search, $stable(r_count), "search changed the count")
    `LSS_ASSERT_ALWAYS(a_no_overwrite, !w_load || w_out_free, "output overwritten while stalled")

endmodule

// ===== dv/lifo_stack_with_search_tb.sv =====
// Self-checking testbench for the LIFO stack with push, pop and search.
`timescale 1ns / 1ps

module lifo_stack_with_search_tb;

    import lss_pkg::*;

    // The block has no code for kind 3; it must act as a no-op with an all-zero result.
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 4;
    // The drain tail covers a full-depth search with margin.
    localparam int DRAIN_TAIL = STACK_DEPTH + 20;
    // The slowest correct stretch without a transaction is a long receiver hold-off
    // (HOLD_OFF_CYCLES) plus a full search; the watchdog limit sits well above it.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_LIMIT = 3000;

    // One expected result: the popped word and the two tuser fields.
    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [STATUS_W-1:0] status;
        logic                found;
    } t_op_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;  // [31:0] value (signed)
    logic [KIND_W-1:0]   s_axis_tuser = '0;  // [1:0] kind
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [WORD_W-1:0]   m_axis_tdata;       // [31:0] popped_word (signed)
    logic [STATUS_W:0]   m_axis_tuser;       // [1:0] status, [2] found

    // Mirror of the stack contents and its fill level, updated on each accepted transaction.
    logic [WORD_W-1:0]   stack_mem [STACK_DEPTH];
    int                  stack_fill = 0;

    // Results still owed by the block, oldest first.
    t_op_result          results_due [$];
    t_op_result          oldest_due;
    int                  mismatch_count = 0;

    // Set by the backpressure test: the receiver holds off for this many cycles once.
    int                  sink_hold_cycles = 0;
    // Forces the sender to offer back-to-back transactions.
    bit                  src_no_gaps = 1'b0;

    lifo_stack_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Applies one operation to the mirrored stack and returns the result the block owes.
    function automatic t_op_result apply_stack_op(input logic [KIND_W-1:0] kind,
                                                  input logic [WORD_W-1:0] word);
        t_op_result res;
        res.word   = '0;
        res.status = STATUS_OK;
        res.found  = 1'b0;
        case (kind)
            KIND_PUSH: begin
                if (stack_fill >= STACK_DEPTH) begin
                    res.status = STATUS_OVERFLOW;
                end else begin
                    stack_mem[stack_fill] = word;
                    stack_fill++;
                end
            end
            KIND_POP: begin
                if (stack_fill == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    stack_fill--;
                    res.word = stack_mem[stack_fill];
                end
            end
            KIND_SEARCH: begin
                // Every stored word counts, a stored zero included.
                for (int i = stack_fill - 1; i >= 0; i--) begin
                    if (stack_mem[i] == word) begin
                        res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Draws the idle cycles before the next transaction of one side. Each run of
    // transactions is drawn at random as a back-to-back stretch or one with random gaps.
    function automatic int next_gap(inout int run_left, inout bit eager);
        if (run_left == 0) begin
            run_left = $urandom_range(5, 40);
            eager = ($urandom_range(0, 3) == 0);
        end
        run_left--;
        return eager ? 0 : $urandom_range(0, 19);
    endfunction

    // Mix of special words, small values that repeat often, and full random words.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom_range(0, 7);
            2: return -$urandom_range(1, 4);
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] exp_v,
                                   input logic [WORD_W-1:0] got_v);
        mismatch_count++;
        $display("%0t ns: mismatch in %s: expected %0h, got %0h", $realtime, what,
                 exp_v, got_v);
    endtask

    // Sender state: the current stretch of gaps or back-to-back transactions.
    int src_run_left = 0;
    bit src_eager = 1'b0;

    // Offers one operation, waits for its transaction, and records the result it owes.
    // Called at a rising edge; returns at the edge that accepted the transaction.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word);
        int gap;
        gap = next_gap(src_run_left, src_eager);
        if (src_no_gaps) begin
            gap = 0;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        results_due.push_back(apply_stack_op(kind, word));
    endtask

    // Receiver: random stalls per result, plus the one long hold-off on request.
    initial begin : result_sink
        int wait_cycles;
        int run_left;
        bit eager;
        run_left = 0;
        eager = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge i_clk);
                sink_hold_cycles = 0;
            end else begin
                wait_cycles = next_gap(run_left, eager);
                if (wait_cycles > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compares each result transaction, field by field, with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, m_axis_tdata);
            end else begin
                oldest_due = results_due.pop_front();
                if (m_axis_tdata !== oldest_due.word) begin
                    report_mismatch("popped_word", oldest_due.word, m_axis_tdata);
                end
                if (m_axis_tuser[STATUS_W-1:0] !== oldest_due.status) begin
                    report_mismatch("status", WORD_W'(oldest_due.status),
                                    WORD_W'(m_axis_tuser[STATUS_W-1:0]));
                end
                if (m_axis_tuser[STATUS_W] !== oldest_due.found) begin
                    report_mismatch("found", WORD_W'(oldest_due.found),
                                    WORD_W'(m_axis_tuser[STATUS_W]));
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction happens on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("lifo_stack_with_search_tb: errors");
        $finish;
    end

    // Operations on an empty stack: pop reports empty, search finds nothing,
    // and the unused kind is a no-op.
    task automatic test_empty_stack();
        send_op(KIND_POP, 32'h1234_5678);
        send_op(KIND_SEARCH, '0);
        send_op(KIND_SEARCH, 32'hffff_ffff);
        send_op(KIND_NONE, 32'hffff_ffff);
        send_op(KIND_POP, '0);
    endtask

    // Extreme words pushed, searched (bottom entry, a stored zero, an absent word)
    // and popped back in reverse order.
    task automatic test_extreme_words();
        send_op(KIND_PUSH, 32'h8000_0000);
        send_op(KIND_PUSH, 32'h7fff_ffff);
        send_op(KIND_PUSH, '0);
        send_op(KIND_PUSH, 32'hffff_ffff);
        send_op(KIND_PUSH, 32'h0000_0001);
        send_op(KIND_SEARCH, 32'h8000_0000);
        send_op(KIND_SEARCH, '0);
        send_op(KIND_SEARCH, 32'h7fff_ffff);
        send_op(KIND_SEARCH, 32'h0000_0002);
        send_op(KIND_NONE, 32'h5a5a_a5a5);
        repeat (5) send_op(KIND_POP, 32'ha5a5_5a5a);
        send_op(KIND_POP, '0);
    endtask

    // Fills the stack to the top, overflows it, searches the full depth, then empties it.
    task automatic test_fill_and_overflow();
        while (stack_fill < STACK_DEPTH) begin
            send_op(KIND_PUSH, $urandom);
        end
        send_op(KIND_PUSH, 32'h8000_0000);
        send_op(KIND_PUSH, $urandom);
        send_op(KIND_SEARCH, stack_mem[0]);
        send_op(KIND_SEARCH, $urandom);
        send_op(KIND_SEARCH, stack_mem[STACK_DEPTH-1]);
        while (stack_fill > 0) begin
            send_op(KIND_POP, $urandom);
        end
        send_op(KIND_POP, $urandom);
    endtask

    // Random traffic whose push/pop balance shifts over time so the fill level
    // sweeps from empty to full; searches mostly hit words that are stored.
    task automatic test_random_traffic(input int count);
        int push_pct;
        int phase_left;
        int pick;
        logic [WORD_W-1:0] word;
        phase_left = 0;
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(30, 80);
                case ($urandom_range(0, 2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            phase_left--;
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_op(KIND_NONE, $urandom);
            end else if (pick < 24) begin
                if (stack_fill > 0 && $urandom_range(0, 9) < 6) begin
                    word = stack_mem[$urandom_range(0, stack_fill - 1)];
                end else begin
                    word = pick_value();
                end
                send_op(KIND_SEARCH, word);
            end else if ($urandom_range(0, 99) < push_pct) begin
                send_op(KIND_PUSH, pick_value());
            end else begin
                send_op(KIND_POP, $urandom);
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender offers transactions
    // back to back, so the block fills its result path and stalls its input.
    task automatic test_output_backpressure();
        sink_hold_cycles = HOLD_OFF_CYCLES;
        src_no_gaps = 1'b1;
        for (int n = 0; n < 40; n++) begin
            case (n % 4)
                0, 1: send_op(KIND_PUSH, pick_value());
                2: send_op(KIND_SEARCH, pick_value());
                default: send_op(KIND_POP, $urandom);
            endcase
        end
        src_no_gaps = 1'b0;
    endtask

    initial begin : main_sequence
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_extreme_words();
        test_fill_and_overflow();
        test_random_traffic(600);
        test_output_backpressure();
        test_random_traffic(650);

        // Stop offering, collect every outstanding result, then watch for strays.
        s_axis_tvalid <= 1'b0;
        while (results_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("lifo_stack_with_search_tb: clean");
        end else begin
            $display("lifo_stack_with_search_tb: errors");
        end
        $finish;
    end

endmodule
